// ===== rtl/core/dfar_pkg.sv =====
// Package for the fixed-answer DNS responder: command item format, parser
// limits, register indexes and reply constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dfar_pkg;

    localparam int REPLY_BYTES_DEF = 64;
    localparam int CMDQ_DEPTH      = 4;

    localparam logic [31:0] ADDR_RESET = 32'hC0A8_0401;
    localparam logic [31:0] TTL_RESET  = 32'd60;

    localparam int HDR_LAST_IDX = 11;
    localparam int NAME_START   = 12;
    localparam int NEED_TERM    = 21;
    localparam int NEED_NAME    = 22;
    localparam int TAIL_LAST    = 3;

    localparam int HDR_FINAL      = 11;
    localparam int HDR_DROP_FINAL = 12;
    localparam int ANS_FINAL      = 16;

    localparam logic [7:0] FLAGS_HI   = 8'h81;
    localparam logic [7:0] FLAGS_LO   = 8'h80;
    localparam logic [7:0] PTR_HI     = 8'hC0;
    localparam logic [7:0] PTR_LO     = 8'h0C;
    localparam logic [7:0] RDLEN_LO   = 8'h04;

    typedef enum logic [0:0] {
        REG_ANSWER_ADDRESS = 1'b0,
        REG_ANSWER_TTL     = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_HEADER = 2'd0,
        CMD_BYTE   = 2'd1,
        CMD_DROP   = 2'd2,
        CMD_ANSWER = 2'd3
    } cmd_kind_t;

    // data: query ID for a header, reply byte in [7:0] otherwise
    // drop_after: header is followed by a drop marker
    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] data;
        logic        drop_after;
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/dfar_front.sv =====
// Front end: parses query bytes and issues reply commands to the queue.
// Depends on dfar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dfar_front #(
    parameter int REPLY_BYTES = dfar_pkg::REPLY_BYTES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   in_byte,
    input  wire logic         in_last,
    input  wire logic         q_full,
    output logic              cmd_push,
    output dfar_pkg::cmd_t    cmd
);
    import dfar_pkg::*;

    localparam int CNT_W = $clog2(REPLY_BYTES + 1);

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_NAME   = 4'b0010,
        PH_TAIL   = 4'b0100,
        PH_SKIP   = 4'b1000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [15:0]        id_reg, id_next;
    logic [2:0]         tail_reg, tail_next;
    logic               accept;
    logic [CNT_W:0]     need_sum;
    logic               overrun;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        need_sum = {1'b0, cnt_reg}
                 + ((in_byte == 8'd0) ? (CNT_W+1)'(NEED_TERM) : (CNT_W+1)'(NEED_NAME));
        overrun  = need_sum > (CNT_W+1)'(REPLY_BYTES);
    end

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        id_next    = id_reg;
        tail_next  = tail_reg;
        cmd_push   = 1'b0;
        cmd        = '{kind: CMD_BYTE, data: {8'd0, in_byte}, drop_after: 1'b0};
        if (accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (cnt_reg == '0) begin
                        id_next = {in_byte, id_reg[7:0]};
                    end else if (cnt_reg == CNT_W'(1)) begin
                        id_next = {id_reg[15:8], in_byte};
                    end
                    if (cnt_reg >= CNT_W'(HDR_LAST_IDX)) begin
                        cmd_push = 1'b1;
                        cmd      = '{kind: CMD_HEADER, data: id_next, drop_after: in_last};
                        if (in_last) begin
                            cnt_next = '0;
                        end else begin
                            phase_next = PH_NAME;
                            cnt_next   = CNT_W'(NAME_START);
                        end
                    end else if (in_last) begin
                        cnt_next = '0;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                PH_NAME: begin
                    cmd_push = 1'b1;
                    if (in_last || overrun) begin
                        cmd.kind = CMD_DROP;
                        cmd.data = '0;
                        if (in_last) begin
                            phase_next = PH_HEADER;
                            cnt_next   = '0;
                            tail_next  = '0;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (in_byte == 8'd0) begin
                            phase_next = PH_TAIL;
                            tail_next  = '0;
                        end
                    end
                end
                PH_TAIL: begin
                    cmd_push = 1'b1;
                    if (in_last && tail_reg < 3'(TAIL_LAST)) begin
                        cmd.kind   = CMD_DROP;
                        cmd.data   = '0;
                        phase_next = PH_HEADER;
                        cnt_next   = '0;
                        tail_next  = '0;
                    end else if (tail_reg == 3'(TAIL_LAST)) begin
                        cmd.kind  = CMD_ANSWER;
                        cnt_next  = '0;
                        tail_next = '0;
                        phase_next = in_last ? PH_HEADER : PH_SKIP;
                    end else begin
                        tail_next = tail_reg + 3'd1;
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                end
                PH_SKIP: begin
                    if (in_last) begin
                        phase_next = PH_HEADER;
                        cnt_next   = '0;
                        tail_next  = '0;
                    end
                end
                default: begin
                    phase_next = PH_HEADER;
                    cnt_next   = '0;
                    tail_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            cnt_reg   <= '0;
            id_reg    <= '0;
            tail_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            id_reg    <= id_next;
            tail_reg  <= tail_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dfar_cmdq.sv =====
// Command queue between front and back end: small register FIFO.
// Depends on dfar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dfar_cmdq (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire dfar_pkg::cmd_t push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                q_valid,
    output dfar_pkg::cmd_t      q_data
);
    import dfar_pkg::*;

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    cmd_t               mem_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = count_reg == CNT_W'(CMDQ_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_data  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dfar_back.sv =====
// Back end: expands reply commands into reply items through an output register,
// one per cycle while the receiver is ready. Depends on dfar_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dfar_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    input  wire dfar_pkg::cmd_t q_data,
    output logic                pop,
    input  wire logic [31:0]    answer_address,
    input  wire logic [31:0]    answer_ttl,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last,
    output logic                out_drop
);
    import dfar_pkg::*;

    cmd_t         cur_reg, cur_next;
    logic         active_reg, active_next;
    logic [4:0]   idx_reg, idx_next;
    logic         valid_reg, valid_next;
    logic [7:0]   byte_reg, byte_next;
    logic         last_reg, last_next;
    logic         drop_reg, drop_next;
    logic         advance;
    logic [4:0]   final_idx;
    logic [7:0]   gen_byte;
    logic         gen_last, gen_drop;

    assign advance   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_drop  = drop_reg;

    always_comb begin
        gen_byte  = 8'd0;
        gen_last  = 1'b0;
        gen_drop  = 1'b0;
        final_idx = 5'd0;
        case (cur_reg.kind)
            CMD_HEADER: begin
                final_idx = cur_reg.drop_after ? 5'(HDR_DROP_FINAL) : 5'(HDR_FINAL);
                case (idx_reg)
                    5'd0:    gen_byte = cur_reg.data[15:8];
                    5'd1:    gen_byte = cur_reg.data[7:0];
                    5'd2:    gen_byte = FLAGS_HI;
                    5'd3:    gen_byte = FLAGS_LO;
                    5'd5:    gen_byte = 8'd1;
                    5'd7:    gen_byte = 8'd1;
                    5'd12: begin
                        gen_last = 1'b1;
                        gen_drop = 1'b1;
                    end
                    default: gen_byte = 8'd0;
                endcase
            end
            CMD_BYTE: begin
                gen_byte = cur_reg.data[7:0];
            end
            CMD_DROP: begin
                gen_last = 1'b1;
                gen_drop = 1'b1;
            end
            CMD_ANSWER: begin
                final_idx = 5'(ANS_FINAL);
                case (idx_reg)
                    5'd0:    gen_byte = cur_reg.data[7:0];
                    5'd1:    gen_byte = PTR_HI;
                    5'd2:    gen_byte = PTR_LO;
                    5'd4:    gen_byte = 8'd1;
                    5'd6:    gen_byte = 8'd1;
                    5'd7:    gen_byte = answer_ttl[31:24];
                    5'd8:    gen_byte = answer_ttl[23:16];
                    5'd9:    gen_byte = answer_ttl[15:8];
                    5'd10:   gen_byte = answer_ttl[7:0];
                    5'd12:   gen_byte = RDLEN_LO;
                    5'd13:   gen_byte = answer_address[31:24];
                    5'd14:   gen_byte = answer_address[23:16];
                    5'd15:   gen_byte = answer_address[15:8];
                    5'd16: begin
                        gen_byte = answer_address[7:0];
                        gen_last = 1'b1;
                    end
                    default: gen_byte = 8'd0;
                endcase
            end
            default: gen_byte = 8'd0;
        endcase
    end

    always_comb begin
        cur_next    = cur_reg;
        active_next = active_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        drop_next   = drop_reg;
        pop         = 1'b0;
        if (advance) begin
            valid_next = active_reg;
            if (active_reg) begin
                byte_next = gen_byte;
                last_next = gen_last;
                drop_next = gen_drop;
            end
        end
        if (!active_reg || (advance && idx_reg == final_idx)) begin
            pop         = q_valid;
            active_next = q_valid;
            idx_next    = '0;
            if (q_valid) begin
                cur_next = q_data;
            end
        end else if (advance) begin
            idx_next = idx_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        drop_reg <= drop_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            valid_reg  <= valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dns_fixed_answer_responder.sv =====
// Fixed-answer DNS responder: one query byte per cycle in, one reply item
// per cycle out while m_tready is high. A reply item passes the command queue,
// the back-end command register and the output register. Header (12-13 items)
// and answer (17 items) bursts drain at one item a cycle from the queue.
// Input stalls only while the command queue is full. aresetn is synchronous:
// it clears parser, queue and output state and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module dns_fixed_answer_responder #(
    parameter int REPLY_BYTES = dfar_pkg::REPLY_BYTES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] query_byte
    input  wire logic         s_tlast,   // query_last
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata,   // [7:0] reply_byte
    output logic              m_tlast,   // reply_last
    output logic              m_tuser,   // [0] reply_drop
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import dfar_pkg::*;

    cmd_t         push_cmd, q_cmd;
    logic         push, q_full, q_valid, pop;
    logic [31:0]  addr_reg, ttl_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= ADDR_RESET;
            ttl_reg  <= TTL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ANSWER_ADDRESS: addr_reg <= cfg_data;
                REG_ANSWER_TTL:     ttl_reg  <= cfg_data;
                default:            addr_reg <= addr_reg;
            endcase
        end
    end

    dfar_front #(
        .REPLY_BYTES (REPLY_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .cmd_push (push),
        .cmd      (push_cmd)
    );

    dfar_cmdq u_cmdq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_cmd)
    );

    dfar_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_data         (q_cmd),
        .pop            (pop),
        .answer_address (addr_reg),
        .answer_ttl     (ttl_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_byte       (m_tdata),
        .out_last       (m_tlast),
        .out_drop       (m_tuser)
    );

endmodule
`default_nettype wire

// ===== rtl/core/dfar_checker.sv =====
// Port-level checks for the fixed-answer DNS responder, bound to the top.
// Depends on dns_fixed_answer_responder.
`timescale 1ns / 1ps
`default_nettype none
module dfar_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    a_drop_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("drop marker without last");

    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 8'd0)
        else $error("drop marker with nonzero byte");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled output item changed");

endmodule

bind dns_fixed_answer_responder dfar_checker u_dfar_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== test/dns_fixed_answer_responder_tb.sv =====
// Self-checking testbench for dns_fixed_answer_responder: sends DNS query bytes,
// predicts every reply item in SystemVerilog, and checks the reply stream.
// Depends on dfar_pkg and the responder RTL only.
`timescale 1ns / 1ps
module dns_fixed_answer_responder_tb;
    import dfar_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int IDLE_PCT     = 27;
    localparam int HOLD_CYCLES  = 160;
    localparam int DRAIN_SLACK  = 12;
    localparam int TOTAL_BYTES  = 310;
    localparam int HDR_RANDOM   = 10;
    localparam int QTYPE_BYTES  = 4;

    typedef enum logic [1:0] {
        QP_HEADER,
        QP_NAME,
        QP_TAIL,
        QP_SKIP
    } query_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drop;
    } reply_item_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] query_byte
    logic        s_tlast;   // query_last
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] reply_byte
    logic        m_tlast;   // reply_last
    logic        m_tuser;   // [0] reply_drop
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    // predictor state
    query_phase_t qp_phase;
    int           qp_offset;
    int           qp_tail;
    logic [15:0]  qp_id;
    logic [31:0]  ans_addr;
    logic [31:0]  ans_ttl;

    reply_item_t  reply_q[$];
    logic [7:0]   pkt[$];

    int  err_count     = 0;
    int  bytes_sent    = 0;
    int  queries_sent  = 0;
    int  replies_seen  = 0;
    int  drops_seen    = 0;
    int  settings_used = 1;
    int  stall_cycles  = 0;
    int  hold_left     = 0;
    bit  hold_req      = 1'b0;
    bit  steady        = 1'b0;

    dns_fixed_answer_responder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    // ---------------- reply predictor ----------------
    function automatic void push_reply(input logic [7:0] d, input logic l, input logic dr);
        reply_item_t r;
        r.data = d;
        r.last = l;
        r.drop = dr;
        reply_q.push_back(r);
    endfunction

    function automatic void push_word(input logic [31:0] w, input logic l);
        push_reply(w[31:24], 1'b0, 1'b0);
        push_reply(w[23:16], 1'b0, 1'b0);
        push_reply(w[15:8], 1'b0, 1'b0);
        push_reply(w[7:0], l, 1'b0);
    endfunction

    function automatic void restart_query();
        qp_phase  = QP_HEADER;
        qp_offset = 0;
        qp_tail   = 0;
    endfunction

    function automatic void predict_reply(input logic [7:0] b, input logic l);
        int need;
        case (qp_phase)
            QP_HEADER: begin
                if (qp_offset == 0)
                    qp_id[15:8] = b;
                else if (qp_offset == 1)
                    qp_id[7:0] = b;
                if (qp_offset >= HDR_LAST_IDX) begin
                    push_reply(qp_id[15:8], 1'b0, 1'b0);
                    push_reply(qp_id[7:0], 1'b0, 1'b0);
                    push_reply(FLAGS_HI, 1'b0, 1'b0);
                    push_reply(FLAGS_LO, 1'b0, 1'b0);
                    push_reply(8'h00, 1'b0, 1'b0);  // QDCOUNT
                    push_reply(8'h01, 1'b0, 1'b0);
                    push_reply(8'h00, 1'b0, 1'b0);  // ANCOUNT
                    push_reply(8'h01, 1'b0, 1'b0);
                    push_word(32'd0, 1'b0);         // NSCOUNT, ARCOUNT
                    if (l) begin
                        push_reply(8'h00, 1'b1, 1'b1);
                        restart_query();
                    end else begin
                        qp_phase  = QP_NAME;
                        qp_offset = NAME_START;
                    end
                end else if (l) begin
                    restart_query();
                end else begin
                    qp_offset++;
                end
            end
            QP_NAME: begin
                need = (b == 8'h00) ? NEED_TERM : NEED_NAME;
                if (l || qp_offset + need > REPLY_BYTES_DEF) begin
                    push_reply(8'h00, 1'b1, 1'b1);
                    if (l)
                        restart_query();
                    else
                        qp_phase = QP_SKIP;
                end else begin
                    push_reply(b, 1'b0, 1'b0);
                    qp_offset++;
                    if (b == 8'h00) begin
                        qp_phase = QP_TAIL;
                        qp_tail  = 0;
                    end
                end
            end
            QP_TAIL: begin
                if (l && qp_tail < TAIL_LAST) begin
                    push_reply(8'h00, 1'b1, 1'b1);
                    restart_query();
                end else begin
                    push_reply(b, 1'b0, 1'b0);
                    qp_tail++;
                    qp_offset++;
                    if (qp_tail >= QTYPE_BYTES) begin
                        push_reply(PTR_HI, 1'b0, 1'b0);
                        push_reply(PTR_LO, 1'b0, 1'b0);
                        push_reply(8'h00, 1'b0, 1'b0);  // type A
                        push_reply(8'h01, 1'b0, 1'b0);
                        push_reply(8'h00, 1'b0, 1'b0);  // class IN
                        push_reply(8'h01, 1'b0, 1'b0);
                        push_word(ans_ttl, 1'b0);
                        push_reply(8'h00, 1'b0, 1'b0);
                        push_reply(RDLEN_LO, 1'b0, 1'b0);
                        push_word(ans_addr, 1'b1);
                        if (l) begin
                            restart_query();
                        end else begin
                            qp_phase  = QP_SKIP;
                            qp_offset = 0;
                            qp_tail   = 0;
                        end
                    end
                end
            end
            default: begin
                if (l)
                    restart_query();
            end
        endcase
    endfunction

    // ---------------- reply checker ----------------
    always @(posedge aclk) begin : check_reply
        reply_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            replies_seen++;
            if (m_tuser)
                drops_seen++;
            if (reply_q.size() == 0) begin
                report_mismatch($sformatf("reply item %02h last %0b drop %0b, none expected",
                                          m_tdata, m_tlast, m_tuser));
            end else begin
                want = reply_q.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch($sformatf("reply_byte %02h, expected %02h",
                                              m_tdata, want.data));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("reply_last %0b, expected %0b",
                                              m_tlast, want.last));
                if (m_tuser !== want.drop)
                    report_mismatch($sformatf("reply_drop %0b, expected %0b",
                                              m_tuser, want.drop));
            end
        end
    end

    // receiver ready, with a counted hold-off on request
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ---------------- drivers ----------------
    // all driver tasks start and end just after a falling edge
    task automatic send_byte(input logic [7:0] b, input logic l);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) begin
            stall_cycles++;
            @(posedge aclk);
        end
        predict_reply(b, l);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_packet(input int count);
        for (int i = 0; i < count; i++)
            send_byte(pkt[i], i == count - 1);
        queries_sent++;
    endtask

    task automatic make_query(input logic [15:0] id, input int name_len, input int trail);
        pkt.delete();
        pkt.push_back(id[15:8]);
        pkt.push_back(id[7:0]);
        repeat (HDR_RANDOM) pkt.push_back(8'($urandom_range(0, 255)));
        repeat (name_len) pkt.push_back(8'($urandom_range(1, 255)));
        pkt.push_back(8'h00);
        repeat (QTYPE_BYTES) pkt.push_back(8'($urandom_range(0, 255)));
        repeat (trail) pkt.push_back(8'($urandom_range(0, 255)));
    endtask

    // input quiet, every expected item out, then latency slack
    task automatic settle();
        s_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_SLACK) @(negedge aclk);
    endtask

    task automatic load_answer(input logic [31:0] addr, input logic [31:0] ttl);
        cfg_valid <= 1'b1;
        cfg_index <= REG_ANSWER_ADDRESS;
        cfg_data  <= addr;
        do @(posedge aclk); while (!cfg_ready);
        ans_addr = addr;
        @(negedge aclk);
        cfg_index <= REG_ANSWER_TTL;
        cfg_data  <= ttl;
        do @(posedge aclk); while (!cfg_ready);
        ans_ttl = ttl;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // ---------------- tests ----------------
    task automatic test_default_answer();
        make_query(16'hFFFF, 2, 0);
        send_packet(pkt.size());
    endtask

    task automatic test_short_queries();
        make_query(16'($urandom), 0, 0);
        send_packet(1);
        send_packet(HDR_LAST_IDX);
        send_packet(NAME_START);   // ends on the last header byte
    endtask

    task automatic test_question_cut();
        make_query(16'($urandom), 3, 0);
        send_packet(NAME_START + 2);        // inside the name
        send_packet(NAME_START + 4);        // on the terminator
        for (int t = 1; t <= TAIL_LAST; t++)
            send_packet(NAME_START + 4 + t); // inside type and class
    endtask

    task automatic test_reply_overrun();
        make_query(16'($urandom), REPLY_BYTES_DEF - NEED_NAME - NAME_START + 1, 0);
        send_packet(pkt.size());            // name fills the reply exactly
        make_query(16'($urandom), 32, 0);
        send_packet(NAME_START + 33);       // overrun, rest skipped
    endtask

    task automatic test_register_extremes();
        settle();
        load_answer(32'h0000_0000, 32'h0000_0000);
        make_query(16'($urandom), 1, 0);
        send_packet(pkt.size());
        settle();
        load_answer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        make_query(16'($urandom), 0, 0);
        send_packet(pkt.size());
    endtask

    task automatic test_backpressure();
        settle();
        steady   = 1'b1;
        hold_req = 1'b1;
        make_query(16'($urandom), 5, 2);
        send_packet(pkt.size());
        settle();
        steady = 1'b0;
    endtask

    // no random idling on either side for the whole random stretch
    task automatic test_random();
        int kind;
        int qn;
        qn     = 0;
        steady = 1'b1;
        while (bytes_sent < TOTAL_BYTES) begin
            if (qn % 2 == 1) begin
                settle();
                load_answer($urandom, $urandom);
            end
            kind = $urandom_range(99);
            if (kind < 70) begin
                if ($urandom_range(9) == 0)
                    make_query(16'($urandom), $urandom_range(28, 34), $urandom_range(0, 3));
                else
                    make_query(16'($urandom), $urandom_range(0, 20), $urandom_range(0, 3));
                send_packet(pkt.size());
            end else if (kind < 88) begin
                make_query(16'($urandom), $urandom_range(0, 20), $urandom_range(0, 3));
                send_packet($urandom_range(1, pkt.size()));
            end else begin
                pkt.delete();
                repeat ($urandom_range(1, 30)) pkt.push_back(8'($urandom_range(0, 255)));
                send_packet(pkt.size());
            end
            qn++;
        end
        steady = 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ANSWER_ADDRESS;
        cfg_data  = 32'd0;
        ans_addr  = ADDR_RESET;
        ans_ttl   = TTL_RESET;
        qp_id     = 16'h0000;
        restart_query();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_default_answer();
        test_short_queries();
        test_question_cut();
        test_reply_overrun();
        test_register_extremes();
        test_backpressure();
        test_random();
        settle();

        if (reply_q.size() != 0)
            report_mismatch($sformatf("%0d reply items never arrived", reply_q.size()));
        $display("Sent %0d query bytes in %0d queries over %0d answer settings; %0d input stalls",
                 bytes_sent, queries_sent, settings_used, stall_cycles);
        $display("Checked %0d reply items, %0d of them drop markers; %0d mismatches",
                 replies_seen, drops_seen, err_count);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dfar_pkg.sv
rtl/core/dfar_front.sv
rtl/core/dfar_cmdq.sv
rtl/core/dfar_back.sv
rtl/core/dns_fixed_answer_responder.sv
rtl/core/dfar_checker.sv
test/dns_fixed_answer_responder_tb.sv
